/* design/bra_pkg.sv */
// Shared constants for the bilinear corner-aligned resizer.
`timescale 1ns / 1ps
package bra_pkg;

    localparam int MAX_IN_DIM_D  = 64;
    localparam int MAX_OUT_DIM_D = 1024;
    localparam int SAMPLE_BITS_D = 16;

    localparam int WBITS = 12;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    localparam logic [1:0] REG_IN_HEIGHT  = 2'd0;
    localparam logic [1:0] REG_IN_WIDTH   = 2'd1;
    localparam logic [1:0] REG_OUT_HEIGHT = 2'd2;
    localparam logic [1:0] REG_OUT_WIDTH  = 2'd3;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;

endpackage

/* design/bra_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/bra_front.sv */
// Front end: accepts requests, writes loads to the plane store, queues pixel jobs.
`timescale 1ns / 1ps
module bra_front #(
    parameter int MAX_IN_DIM  = bra_pkg::MAX_IN_DIM_D,
    parameter int MAX_OUT_DIM = bra_pkg::MAX_OUT_DIM_D,
    parameter int SAMPLE_BITS = bra_pkg::SAMPLE_BITS_D
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     clr,
    input  logic [$clog2(MAX_IN_DIM*MAX_IN_DIM+1)-1:0] plane_size,
    input  logic [$clog2(MAX_OUT_DIM+1)-1:0]         out_h,
    input  logic [$clog2(MAX_OUT_DIM+1)-1:0]         out_w,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic                                     in_func,
    input  logic [SAMPLE_BITS-1:0]                   in_sample,
    output logic                                     st_we,
    output logic [$clog2(MAX_IN_DIM*MAX_IN_DIM)-1:0] st_waddr,
    output logic [SAMPLE_BITS-1:0]                   st_wdata,
    output logic                                     job_valid,
    input  logic                                     job_ready,
    output logic [$clog2(MAX_OUT_DIM)-1:0]           job_row,
    output logic [$clog2(MAX_OUT_DIM)-1:0]           job_col,
    output logic                                     job_last
);
    import bra_pkg::*;

    localparam int DEPTH = MAX_IN_DIM * MAX_IN_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int OW    = $clog2(MAX_OUT_DIM);
    localparam int OD    = $clog2(MAX_OUT_DIM + 1);
    localparam int QW    = 2 * OW + 1;

    logic [AW-1:0] lp_reg, lp_next;
    logic [OW-1:0] row_reg, row_next, col_reg, col_next;
    logic          take, is_req, last_pix;
    logic [PW-1:0] lp_inc;

    // Two-entry job queue between front and back.
    logic [QW-1:0] q_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          rd_ptr_reg, wr_ptr_reg;
    logic          push, pop;

    // A load waits until no pixel job is queued or being computed, so that
    // every pixel sees the store as it was when its request arrived.
    assign is_req   = (in_func == FUNC_REQUEST);
    assign in_ready = !clr && (is_req ? (cnt_reg != 2'd2) : (cnt_reg == 2'd0 && job_ready));
    assign take     = in_valid && in_ready;
    assign push     = take && is_req;
    assign pop      = job_valid && job_ready;

    // Load path writes the store directly.
    assign st_we    = take && !is_req;
    assign st_waddr = lp_reg;
    assign st_wdata = in_sample;
    assign lp_inc   = PW'(lp_reg) + PW'(1);

    always_comb begin
        lp_next = lp_reg;
        if (st_we) begin
            lp_next = (lp_inc >= plane_size) ? '0 : lp_inc[AW-1:0];
        end
    end

    // Output raster position.
    assign last_pix = (OD'(row_reg) + OD'(1) == out_h) && (OD'(col_reg) + OD'(1) == out_w);

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (push) begin
            if (OD'(col_reg) + OD'(1) >= out_w) begin
                col_next = '0;
                row_next = (OD'(row_reg) + OD'(1) >= out_h) ? '0 : row_reg + OW'(1);
            end else begin
                col_next = col_reg + OW'(1);
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        if (!push && pop) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            lp_reg     <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            cnt_reg    <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            lp_reg  <= lp_next;
            row_reg <= row_next;
            col_reg <= col_next;
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= {last_pix, col_reg, row_reg};
        end
    end

    assign job_valid = (cnt_reg != 2'd0);
    assign job_row   = q_reg[rd_ptr_reg][OW-1:0];
    assign job_col   = q_reg[rd_ptr_reg][2*OW-1:OW];
    assign job_last  = q_reg[rd_ptr_reg][2*OW];

endmodule

/* design/bra_back.sv */
// Back end: serial weight divisions, four-tap multiply-accumulate, round and saturate.
`timescale 1ns / 1ps
module bra_back #(
    parameter int MAX_IN_DIM  = bra_pkg::MAX_IN_DIM_D,
    parameter int MAX_OUT_DIM = bra_pkg::MAX_OUT_DIM_D,
    parameter int SAMPLE_BITS = bra_pkg::SAMPLE_BITS_D
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic [$clog2(MAX_IN_DIM+1)-1:0]          in_h,
    input  logic [$clog2(MAX_IN_DIM+1)-1:0]          in_w,
    input  logic [$clog2(MAX_OUT_DIM+1)-1:0]         out_h,
    input  logic [$clog2(MAX_OUT_DIM+1)-1:0]         out_w,
    input  logic                                     job_valid,
    output logic                                     job_ready,
    input  logic [$clog2(MAX_OUT_DIM)-1:0]           job_row,
    input  logic [$clog2(MAX_OUT_DIM)-1:0]           job_col,
    input  logic                                     job_last,
    output logic [$clog2(MAX_IN_DIM*MAX_IN_DIM)-1:0] st_raddr,
    input  logic [SAMPLE_BITS-1:0]                   st_rdata,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [SAMPLE_BITS-1:0]                   out_pixel,
    output logic                                     out_last
);
    import bra_pkg::*;

    localparam int IW  = $clog2(MAX_IN_DIM + 1);
    localparam int IX  = $clog2(MAX_IN_DIM);
    localparam int OW  = $clog2(MAX_OUT_DIM);
    localparam int OD  = $clog2(MAX_OUT_DIM + 1);
    localparam int AW  = $clog2(MAX_IN_DIM * MAX_IN_DIM);
    // Numerator o*(in-1) and quotient widths.
    localparam int NW  = OW + IW;
    // Remainder scaled: rem*2^13 + den needs OD+14 bits; quotient <= 4096.
    localparam int RW  = OD + WBITS + 2;
    localparam int WW  = WBITS + 1;
    localparam int PRW = 2 * WW;
    localparam int ACW = SAMPLE_BITS + PRW + 3;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIVQ  = 4'd1;
    localparam logic [3:0] S_DIVW  = 4'd2;
    localparam logic [3:0] S_AXIS  = 4'd3;
    localparam logic [3:0] S_TAP   = 4'd4;
    localparam logic [3:0] S_ROUND = 4'd5;

    logic [3:0]       st_reg, st_next;
    logic             axis_reg;            // 0 = rows, 1 = columns
    logic [4:0]       bit_reg;
    logic [NW-1:0]    num_reg;
    logic [NW-1:0]    quo_reg;
    logic [OD-1:0]    rem_reg;
    logic [RW-1:0]    dn_reg;
    logic [RW-1:0]    wr_reg;              // running remainder for weight division
    logic [WW-1:0]    wq_reg;
    logic [OW-1:0]    col_hold_reg;
    logic             last_hold_reg;
    logic [IX-1:0]    h1_reg, w1_reg;
    logic [WW-1:0]    wh_reg, ww_reg;
    logic [2:0]       tap_reg;
    logic [PRW-1:0]   wprod_reg;
    logic [ACW-1:0]   acc_reg;
    logic             out_valid_reg;
    logic [SAMPLE_BITS-1:0] pix_reg;
    logic             last_reg;

    logic [IW-1:0]    in_sz;
    logic [OD-1:0]    out_sz, den;
    logic [OD:0]      trial;
    logic [OD-1:0]    rem_step;
    logic [NW-1:0]    quo_step;
    logic [RW:0]      wtrial;
    logic             hp, wp;
    logic [IX-1:0]    tr, tc;
    logic [WW-1:0]    wa, wb;
    logic signed [ACW-1:0] tprod;
    logic signed [ACW-1:0] rnd;
    logic signed [ACW-WBITS*2-1:0] qv;
    logic [IX-1:0]    idx_clamp;
    logic [WW-1:0]    w1_clamp;

    // Bit b of the weight dividend rem*2^(WBITS+1) + den, taken from live registers.
    function automatic logic dividend_bit(input logic [4:0] b);
        logic [RW-1:0] d;
        d = (RW'(rem_reg) << (WBITS + 1)) + RW'(den);
        return d[b];
    endfunction

    assign in_sz  = axis_reg ? in_w : in_h;
    assign out_sz = axis_reg ? out_w : out_h;
    assign den    = out_sz - OD'(1);

    // One restoring division step for the integer position.
    assign trial    = {rem_reg, num_reg[NW-1]} - {1'b0, den};
    assign rem_step = trial[OD] ? {rem_reg[OD-2:0], num_reg[NW-1]} : trial[OD-1:0];
    assign quo_step = {quo_reg[NW-2:0], !trial[OD]};
    // One restoring step for the weight: (rem*2^13 + den) / (2*den).
    assign wtrial = {wr_reg, 1'b0} - {1'b0, dn_reg};

    assign idx_clamp = (quo_reg >= NW'(in_sz)) ? IX'(in_sz - IW'(1)) : quo_reg[IX-1:0];
    assign w1_clamp  = (wq_reg > WW'(1 << WBITS)) ? WW'(1 << WBITS) : wq_reg;

    assign hp = (IW'(h1_reg) + IW'(1) < in_h);
    assign wp = (IW'(w1_reg) + IW'(1) < in_w);

    // Tap select: bit 1 picks the far row, bit 0 the far column.
    assign tr = h1_reg + ((tap_reg[1] && hp) ? IX'(1) : IX'(0));
    assign tc = w1_reg + ((tap_reg[0] && wp) ? IX'(1) : IX'(0));
    assign wa = tap_reg[1] ? wh_reg : WW'(1 << WBITS) - wh_reg;
    assign wb = tap_reg[0] ? ww_reg : WW'(1 << WBITS) - ww_reg;
    assign st_raddr = AW'(tr) * AW'(in_w) + AW'(tc);

    // Store data arrives in the cycle after the address; wprod_reg aligns with it.
    assign tprod = ACW'($signed(st_rdata)) * $signed({1'b0, wprod_reg});
    assign rnd   = $signed(acc_reg) + $signed(ACW'(1 << (2 * WBITS - 1)));
    assign qv    = rnd[ACW-1:2*WBITS];

    assign job_ready = (st_reg == S_IDLE);

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (job_valid) st_next = S_DIVQ;
            S_DIVQ:  if (out_sz <= OD'(1)) st_next = S_AXIS;
                     else if (bit_reg == 5'd0) st_next = S_DIVW;
            S_DIVW:  if (bit_reg == 5'd0) st_next = S_AXIS;
            S_AXIS:  st_next = axis_reg ? S_TAP : S_DIVQ;
            S_TAP:   if (tap_reg == 3'd4) st_next = S_ROUND;
            S_ROUND: if (!out_valid_reg || out_ready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == S_ROUND && (!out_valid_reg || out_ready)) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (st_reg)
            S_IDLE: begin
                axis_reg      <= 1'b0;
                col_hold_reg  <= job_col;
                last_hold_reg <= job_last;
                num_reg       <= NW'(job_row) * NW'(in_h - IW'(1));
                rem_reg       <= '0;
                quo_reg       <= '0;
                bit_reg       <= 5'(NW - 1);
            end
            S_DIVQ: begin
                if (out_sz <= OD'(1)) begin
                    quo_reg <= '0;
                    wq_reg  <= '0;
                end else begin
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                    if (bit_reg == 5'd0) begin
                        // Weight division dividend rem*2^13+den, shifted in MSB first.
                        wr_reg  <= '0;
                        dn_reg  <= RW'({den, 1'b0});
                        wq_reg  <= '0;
                        bit_reg <= 5'(RW - 1);
                        num_reg <= '0;
                    end else begin
                        num_reg <= {num_reg[NW-2:0], 1'b0};
                        bit_reg <= bit_reg - 5'd1;
                    end
                end
            end
            S_DIVW: begin
                // Divisor is even, so the subtraction can ignore the incoming bit.
                if (!wtrial[RW]) begin
                    wr_reg <= wtrial[RW-1:0] | RW'(dividend_bit(bit_reg));
                    wq_reg <= {wq_reg[WW-2:0], 1'b1};
                end else begin
                    wr_reg <= {wr_reg[RW-2:0], dividend_bit(bit_reg)};
                    wq_reg <= {wq_reg[WW-2:0], 1'b0};
                end
                bit_reg <= bit_reg - 5'd1;
            end
            S_AXIS: begin
                if (!axis_reg) begin
                    h1_reg  <= idx_clamp;
                    wh_reg  <= w1_clamp;
                    axis_reg <= 1'b1;
                    num_reg <= NW'(col_hold_reg) * NW'(in_w - IW'(1));
                    rem_reg <= '0;
                    quo_reg <= '0;
                    wq_reg  <= '0;
                    bit_reg <= 5'(NW - 1);
                end else begin
                    w1_reg  <= idx_clamp;
                    ww_reg  <= w1_clamp;
                    tap_reg <= '0;
                    acc_reg <= '0;
                end
            end
            S_TAP: begin
                tap_reg   <= tap_reg + 3'd1;
                wprod_reg <= PRW'(wa) * PRW'(wb);
                if (tap_reg != 3'd0) acc_reg <= acc_reg + tprod;
            end
            S_ROUND: begin
                if (!out_valid_reg || out_ready) begin
                    last_reg <= last_hold_reg;
                    if (qv > $signed((ACW-2*WBITS)'((1 << (SAMPLE_BITS - 1)) - 1)))
                        pix_reg <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    else if (qv < -$signed((ACW-2*WBITS)'(1 << (SAMPLE_BITS - 1))))
                        pix_reg <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                    else
                        pix_reg <= qv[SAMPLE_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = pix_reg;
    assign out_last  = last_reg;

endmodule

/* design/bilinear_resize_align_corners.sv */
// Top level of the bilinear corner-aligned plane resizer.
//
// Usage: set the four size registers over the cfg channel while idle; each
// write also rewinds the load pointer and the output raster position. Send
// load requests (tuser = 0) carrying samples in raster order, then send pixel
// requests (tuser = 1); each pixel request yields one result on m_ with
// tlast high on the final pixel of the output plane. Loads yield nothing.
// A load is written to the plane store in the cycle it is accepted; it is
// held off while any pixel request is still queued or being computed.
// Pixel requests enter a two-entry job queue; the back end takes one job at
// a time: per axis a 17-step position division, a 25-step weight division
// and a setup state, then a tap state that reads and accumulates the four
// taps and a rounding state. A new job starts only once the previous pixel
// has left the rounding state; an axis whose output size is 1 skips both
// divisions.
// The result register holds a pixel while m_axis_tready is low; the back end
// then stalls, and once the job queue is full s_axis_tready drops.
// Reset clears all control state and sets every size register to 1; the
// plane store is not cleared and must be loaded before it is read.
`timescale 1ns / 1ps
module bilinear_resize_align_corners #(
    parameter int MAX_IN_DIM  = bra_pkg::MAX_IN_DIM_D,
    parameter int MAX_OUT_DIM = bra_pkg::MAX_OUT_DIM_D,
    parameter int SAMPLE_BITS = bra_pkg::SAMPLE_BITS_D
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic                               s_axis_tuser,  // func
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata,  // [SAMPLE_BITS-1:0] pixel
    output logic                               m_axis_tlast,  // last_of_plane
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bra_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [bra_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import bra_pkg::*;

    localparam int IW    = $clog2(MAX_IN_DIM + 1);
    localparam int OD    = $clog2(MAX_OUT_DIM + 1);
    localparam int OW    = $clog2(MAX_OUT_DIM);
    localparam int DEPTH = MAX_IN_DIM * MAX_IN_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int TDW   = ((SAMPLE_BITS + 7) / 8) * 8;

    logic [IW-1:0] in_h_reg, in_w_reg;
    logic [OD-1:0] out_h_reg, out_w_reg;
    logic [PW-1:0] plane_size;
    logic          cfg_take;
    logic [6:0]    cin;
    logic [10:0]   cout;
    logic [IW-1:0] cin_cl;
    logic [OD-1:0] cout_cl;

    logic                   st_we;
    logic [AW-1:0]          st_waddr, st_raddr;
    logic [SAMPLE_BITS-1:0] st_wdata, st_rdata, pix;
    logic                   job_valid, job_ready, job_last;
    logic [OW-1:0]          job_row, job_col;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign cin  = cfg_data[6:0];
    assign cout = cfg_data;
    assign cin_cl  = (cin == 7'd0) ? IW'(1) :
                     (32'(cin) > MAX_IN_DIM) ? IW'(MAX_IN_DIM) : IW'(cin);
    assign cout_cl = (cout == 11'd0) ? OD'(1) :
                     (32'(cout) > MAX_OUT_DIM) ? OD'(MAX_OUT_DIM) : OD'(cout);

    // Size registers with range clamping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_h_reg  <= IW'(1);
            in_w_reg  <= IW'(1);
            out_h_reg <= OD'(1);
            out_w_reg <= OD'(1);
        end else if (cfg_take) begin
            case (cfg_index)
                REG_IN_HEIGHT:  in_h_reg  <= cin_cl;
                REG_IN_WIDTH:   in_w_reg  <= cin_cl;
                REG_OUT_HEIGHT: out_h_reg <= cout_cl;
                REG_OUT_WIDTH:  out_w_reg <= cout_cl;
                default: ;
            endcase
        end
    end

    // Plane size follows the size registers without delay.
    assign plane_size = PW'(in_h_reg) * PW'(in_w_reg);

    bra_front #(.MAX_IN_DIM(MAX_IN_DIM), .MAX_OUT_DIM(MAX_OUT_DIM),
                .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .clr(cfg_take),
        .plane_size(plane_size), .out_h(out_h_reg), .out_w(out_w_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_func(s_axis_tuser), .in_sample(s_axis_tdata[SAMPLE_BITS-1:0]),
        .st_we(st_we), .st_waddr(st_waddr), .st_wdata(st_wdata),
        .job_valid(job_valid), .job_ready(job_ready),
        .job_row(job_row), .job_col(job_col), .job_last(job_last)
    );

    bra_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_store (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    bra_back #(.MAX_IN_DIM(MAX_IN_DIM), .MAX_OUT_DIM(MAX_OUT_DIM),
               .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_h(in_h_reg), .in_w(in_w_reg), .out_h(out_h_reg), .out_w(out_w_reg),
        .job_valid(job_valid), .job_ready(job_ready),
        .job_row(job_row), .job_col(job_col), .job_last(job_last),
        .st_raddr(st_raddr), .st_rdata(st_rdata),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_pixel(pix), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = TDW'(pix);

    // A held result must not change while the receiver stalls.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("result changed under stall");

    // The job queue never accepts a pixel request while full.
    a_q: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_REQUEST
        |-> u_front.cnt_reg != 2'd2)
        else $error("queue overrun");

    // A size register never holds zero.
    a_sz: assert property (@(posedge aclk) disable iff (!aresetn)
        in_h_reg != '0 && in_w_reg != '0 && out_h_reg != '0 && out_w_reg != '0)
        else $error("size register is zero");

endmodule
